>>> rtl/core/p2w_pkg.sv
// Shared constants and types for the pixel to wavetable row trimmer.
// Used by p2w_sample_path and pixel_to_wavetable_row_trim; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package p2w_pkg;

	// Pixels in one row.
	localparam int FRAME_LENGTH = 1024;
	localparam int COL_W = $clog2(FRAME_LENGTH);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_LENGTH - 1);

	// Q16 luma weights and full scale 255 * 65536.
	localparam logic [23:0] LUMA_WR = 24'd19588;
	localparam logic [23:0] LUMA_WG = 24'd38470;
	localparam logic [23:0] LUMA_WB = 24'd7471;
	localparam logic [24:0] LUMA_FULL = 25'd16711680;

	// ceil(2^31 / 255): exact floor division by 255 for dividends below 2^24.
	localparam logic [23:0] RECIP_255 = 24'd8421505;
	localparam int RECIP_SHIFT = 31;

	// Row tracker reset values.
	localparam logic signed [15:0] ROW_MIN_INIT = 16'sd32767;
	localparam logic signed [15:0] ROW_MAX_INIT = -16'sd32767;
	localparam logic [8:0] DROP_MAX = 9'd511;

	// Configuration register indexes.
	localparam logic [1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_CHANNELS  = 2'd1;
	localparam logic [1:0] CFG_INVERT    = 2'd2;

	// Sample magnitude and sign handed from the sample path to the row stage.
	typedef struct packed {
		logic        valid;
		logic        neg;
		logic [14:0] mag;
	} smp_t;

endpackage
`default_nettype wire

>>> rtl/core/p2w_sample_path.sv
// Four-stage pipeline from an RGB pixel to a signed sample magnitude and sign.
// Depends on p2w_pkg for weights, the reciprocal of 255 and smp_t.
`timescale 1ns / 1ps
`default_nettype none
module p2w_sample_path (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        red,
	input  wire logic [7:0]        green,
	input  wire logic [7:0]        blue,
	input  wire logic [2:0]        channel_count,
	output p2w_pkg::smp_t          smp,
	input  wire logic              smp_ready
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic [7:0]  r_s1, g_s1, b_s1;
	logic [23:0] d_s2;
	logic        neg_s2, neg_s3, neg_s4;
	logic [22:0] t_s3;
	logic [14:0] q_s4;

	logic [7:0]  g_sel, b_sel;
	logic [23:0] luma;
	logic [24:0] luma2;
	logic [38:0] scaled;
	logic [46:0] prod;

	// Each stage takes a word when it is empty or its contents move on.
	assign rdy_s4 = !v_s4 || smp_ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_comb begin
		g_sel = (channel_count < 3'd2) ? r_s1 : g_s1;
		b_sel = (channel_count < 3'd3) ? r_s1 : b_s1;
		luma = 24'(r_s1) * p2w_pkg::LUMA_WR + 24'(g_sel) * p2w_pkg::LUMA_WG
			+ 24'(b_sel) * p2w_pkg::LUMA_WB;
		luma2 = {luma, 1'b0};
		// Multiply by 32767 as x * 2^15 - x, then drop the 65536 part of the divisor.
		scaled = {d_s2, 15'b0} - 39'(d_s2);
		prod = 47'(t_s3) * 47'(p2w_pkg::RECIP_255);
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			r_s1 <= red;
			g_s1 <= green;
			b_s1 <= blue;
		end
		if (rdy_s2 && v_s1) begin
			// Work on the magnitude so that the division truncates toward zero.
			if (luma2 >= p2w_pkg::LUMA_FULL) begin
				d_s2   <= 24'(luma2 - p2w_pkg::LUMA_FULL);
				neg_s2 <= 1'b0;
			end else begin
				d_s2   <= 24'(p2w_pkg::LUMA_FULL - luma2);
				neg_s2 <= 1'b1;
			end
		end
		if (rdy_s3 && v_s2) begin
			t_s3   <= scaled[38:16];
			neg_s3 <= neg_s2;
		end
		if (rdy_s4 && v_s3) begin
			q_s4   <= prod[p2w_pkg::RECIP_SHIFT+14:p2w_pkg::RECIP_SHIFT];
			neg_s4 <= neg_s3;
		end
	end

	assign smp.valid = v_s4;
	assign smp.neg   = neg_s4;
	assign smp.mag   = q_s4;

`ifndef SYNTHESIS
	a_mag_peak: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> q_s4 <= 15'd32767)
		else $error("sample magnitude above peak");
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !smp_ready) |=> (v_s4 && $stable(q_s4) && $stable(neg_s4)))
		else $error("stalled stage four word changed");
	a_d_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> d_s2 <= 24'd16711680)
		else $error("luma offset out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/core/pixel_to_wavetable_row_trim.sv
// Top level: configuration registers, sample pipeline and row range tracker.
// Depends on p2w_pkg and p2w_sample_path.
// A pixel is registered in sample path stages s1 to s4 and then in the output register, where its result word is valid.
// Throughput: one pixel per cycle; a held output fills the five stages, after which
// s_axis_tready falls in the same cycle, as the ready chain is combinational.
// Row minimum, maximum and drop count are updated in the single output stage.
// Reset (arst_n low) empties the pipeline, clears the row trackers and drop count,
// and sets threshold 3000, three channels and no inversion.
`timescale 1ns / 1ps
`default_nettype none
module pixel_to_wavetable_row_trim (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // sample [15:0], row_range [31:16],
	                                        // dropped_rows [40:32], zero [47:41]
	output logic             m_axis_tlast,  // row_end
	output logic             m_axis_tuser,  // row_keep
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	logic [15:0] threshold_q;
	logic [2:0]  channels_q;
	logic        invert_q;

	p2w_pkg::smp_t smp;
	logic          smp_ready;

	logic [p2w_pkg::COL_W-1:0] column_q;
	logic signed [15:0] row_min_q, row_max_q;
	logic [8:0]  dropped_q;

	logic        out_valid_q;
	logic signed [15:0] sample_q;
	logic [15:0] range_q;
	logic [8:0]  dropped_out_q;
	logic        last_q, keep_q;

	logic signed [15:0] s_val, new_min, new_max;
	logic [15:0] range_new;
	logic        last, keep, take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 16'd3000;
			channels_q  <= 3'd3;
			invert_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				p2w_pkg::CFG_THRESHOLD: threshold_q <= cfg_wdata;
				p2w_pkg::CFG_CHANNELS:  channels_q  <= cfg_wdata[2:0];
				p2w_pkg::CFG_INVERT:    invert_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	p2w_sample_path u_path (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.red           (s_axis_tdata[7:0]),
		.green         (s_axis_tdata[15:8]),
		.blue          (s_axis_tdata[23:16]),
		.channel_count (channels_q),
		.smp           (smp),
		.smp_ready     (smp_ready)
	);

	assign smp_ready = !out_valid_q || m_axis_tready;
	assign take = smp.valid && smp_ready;

	always_comb begin
		s_val = smp.neg ? -$signed({1'b0, smp.mag}) : $signed({1'b0, smp.mag});
		new_min = (s_val < row_min_q) ? s_val : row_min_q;
		new_max = (s_val > row_max_q) ? s_val : row_max_q;
		// Both trackers now include this sample, so max is never below min.
		range_new = 16'(new_max - new_min);
		last = (column_q >= p2w_pkg::COL_LAST);
		keep = last && (range_new > threshold_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			row_min_q   <= p2w_pkg::ROW_MIN_INIT;
			row_max_q   <= p2w_pkg::ROW_MAX_INIT;
			dropped_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (smp_ready) out_valid_q <= smp.valid;
			if (take) begin
				if (last) begin
					column_q  <= '0;
					row_min_q <= p2w_pkg::ROW_MIN_INIT;
					row_max_q <= p2w_pkg::ROW_MAX_INIT;
					if (!keep && dropped_q != p2w_pkg::DROP_MAX) dropped_q <= dropped_q + 9'd1;
				end else begin
					column_q  <= column_q + 1'b1;
					row_min_q <= new_min;
					row_max_q <= new_max;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_q <= invert_q ? -s_val : s_val;
			range_q  <= range_new;
			last_q   <= last;
			keep_q   <= keep;
			dropped_out_q <= (last && !keep && dropped_q != p2w_pkg::DROP_MAX)
				? dropped_q + 9'd1 : dropped_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, dropped_out_q, range_q, sample_q};
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = keep_q;

`ifndef SYNTHESIS
	a_keep_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!keep_q || last_q))
		else $error("row kept on a word that does not end the row");
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(take && last) |=> (column_q == '0 && row_min_q == p2w_pkg::ROW_MIN_INIT))
		else $error("row trackers not cleared after row end");
	a_drop_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> dropped_q >= $past(dropped_q))
		else $error("drop count went down");
	a_sample_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> sample_q != 16'sh8000)
		else $error("sample outside symmetric range");
`endif

endmodule
`default_nettype wire

>>> tb/tb_pixel_to_wavetable_row_trim.sv
`timescale 1ns / 1ps
// Self-checking testbench for pixel_to_wavetable_row_trim: streams pixels, writes the
// registers between phases and checks every result word against its own row model.
// Depends on p2w_pkg and the RTL of the block; reads no files.
module tb_pixel_to_wavetable_row_trim;

	localparam int ROW_PIXELS = p2w_pkg::FRAME_LENGTH;
	localparam longint WEIGHT_RED = 19588;
	localparam longint WEIGHT_GREEN = 38470;
	localparam longint WEIGHT_BLUE = 7471;
	localparam longint LUMA_SCALE = 255 * 65536;
	localparam longint PCM_PEAK = 32767;
	localparam int ROW_LO_INIT = 32767;
	localparam int ROW_HI_INIT = -32767;
	localparam int DROP_LIMIT = 511;
	localparam int IDLE_PERCENT = 26;
	localparam longint CYCLE_LIMIT = 200_000;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               row_end;
		logic               row_keep;
		logic [15:0]        row_range;
		logic [8:0]         dropped_rows;
	} row_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = p2w_pkg::CFG_THRESHOLD;
	logic [15:0] cfg_wdata = '0;

	// Register copies and row state as the block should hold them.
	int unsigned thresh_cfg = 3000;
	int unsigned chan_cfg = 3;
	bit          invert_cfg = 1'b0;
	int          col_pos = 0;
	int          row_lo = ROW_LO_INIT;
	int          row_hi = ROW_HI_INIT;
	int          drop_total = 0;

	row_word_t expected_words[$];
	int        mismatches = 0;
	int        words_seen = 0;
	int        rows_seen = 0;
	int        rows_kept = 0;
	int        pixels_sent = 0;
	bit        idling_on = 1'b0;
	int        hold_left = 0;
	longint    cycle_count = 0;

	pixel_to_wavetable_row_trim u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pixel_sample(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		longint luma;
		longint num;
		logic [7:0] gg;
		logic [7:0] bb;
		gg = (chan_cfg < 2) ? r : g;
		bb = (chan_cfg < 3) ? r : b;
		luma = WEIGHT_RED * longint'(r) + WEIGHT_GREEN * longint'(gg)
			+ WEIGHT_BLUE * longint'(bb);
		num = (2 * luma - LUMA_SCALE) * PCM_PEAK;
		// Signed division truncates toward zero, as the sample mapping requires.
		return int'(num / LUMA_SCALE);
	endfunction

	function automatic row_word_t next_row_word(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		row_word_t wd;
		int s;
		int span;
		s = pixel_sample(r, g, b);
		if (s < row_lo) row_lo = s;
		if (s > row_hi) row_hi = s;
		span = (row_hi >= row_lo) ? row_hi - row_lo : 0;
		wd.sample = invert_cfg ? 16'(-s) : 16'(s);
		wd.row_end = (col_pos >= ROW_PIXELS - 1);
		wd.row_keep = 1'b0;
		wd.row_range = 16'(span);
		if (wd.row_end) begin
			wd.row_keep = (span > int'(thresh_cfg));
			if (!wd.row_keep && drop_total < DROP_LIMIT) drop_total++;
			col_pos = 0;
			row_lo = ROW_LO_INIT;
			row_hi = ROW_HI_INIT;
		end else begin
			col_pos++;
		end
		wd.dropped_rows = 9'(drop_total);
		return wd;
	endfunction

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, g, r};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_words.insert(expected_words.size(), next_row_word(r, g, b));
		pixels_sent++;
	endtask

	task automatic send_random_pixel();
		send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			p2w_pkg::CFG_THRESHOLD: thresh_cfg = 32'(value);
			p2w_pkg::CFG_CHANNELS: chan_cfg = 32'(value[2:0]);
			p2w_pkg::CFG_INVERT: invert_cfg = value[0];
			default: ;
		endcase
	endtask

	task automatic configure(input int unsigned thr, input int unsigned chans, input bit inv);
		write_reg(p2w_pkg::CFG_THRESHOLD, 16'(thr));
		write_reg(p2w_pkg::CFG_CHANNELS, 16'(chans));
		write_reg(p2w_pkg::CFG_INVERT, 16'(inv));
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin : check_words
		row_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			words_seen++;
			if (expected_words.size() == 0) begin
				mismatches++;
				$display("%0t: word with no expectation, expected none actual sample %0d",
					$time, $signed(m_axis_tdata[15:0]));
			end else begin
				want = expected_words.pop_front();
				if (want.row_end) begin
					rows_seen++;
					if (want.row_keep) rows_kept++;
				end
				check_field("sample", int'(want.sample), int'($signed(m_axis_tdata[15:0])));
				check_field("row_range", int'(want.row_range), int'(m_axis_tdata[31:16]));
				check_field("dropped_rows", int'(want.dropped_rows),
					int'(m_axis_tdata[40:32]));
				check_field("padding", 0, int'(m_axis_tdata[47:41]));
				check_field("row_end", int'(want.row_end), int'(m_axis_tlast));
				check_field("row_keep", int'(want.row_keep), int'(m_axis_tuser));
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when a test asks for one.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else begin
			m_axis_tready <= !(idling_on && $urandom_range(99) < IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still outstanding",
				cycle_count, expected_words.size());
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic test_directed_pixels();
		int unsigned chan_list[5] = '{0, 1, 2, 4, 7};
		// Reset values: three channels, no inversion.
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'hFF, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hFF);
		send_pixel(8'hAA, 8'h55, 8'hAA);
		send_pixel(8'h55, 8'hAA, 8'h55);
		wait_drained();
		foreach (chan_list[i]) begin
			configure(3000, chan_list[i], 1'b0);
			send_pixel(8'h80, 8'hFF, 8'h00);
			send_pixel(8'h10, 8'h00, 8'hFF);
			wait_drained();
		end
		// Upper data bits are dropped, and the unused index must change nothing.
		write_reg(p2w_pkg::CFG_CHANNELS, 16'hFFFB);
		write_reg(p2w_pkg::CFG_INVERT, 16'hFFFF);
		write_reg(CFG_UNUSED, 16'h1234);
		cfg_we <= 1'b0;
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h7F, 8'h80, 8'h7F);
		wait_drained();
	endtask

	task automatic test_row_end(input bit keep_row);
		logic [7:0] pr;
		logic [7:0] pg;
		logic [7:0] pb;
		int s;
		int lo;
		int hi;
		while (col_pos != ROW_PIXELS - 1) send_random_pixel();
		wait_drained();
		// The closing pixel is chosen first, so the threshold can sit exactly on the row
		// range, which drops the row, or one below it, which keeps the row.
		pr = 8'($urandom_range(255));
		pg = 8'($urandom_range(255));
		pb = 8'($urandom_range(255));
		s = pixel_sample(pr, pg, pb);
		lo = (s < row_lo) ? s : row_lo;
		hi = (s > row_hi) ? s : row_hi;
		configure(32'(hi - lo - int'(keep_row)), chan_cfg, 1'($urandom_range(1)));
		send_pixel(pr, pg, pb);
		wait_drained();
	endtask

	task automatic test_random_rows();
		logic [7:0] base_r;
		logic [7:0] base_g;
		logic [7:0] base_b;
		for (int chunk = 0; chunk < 2; chunk++) begin
			configure($urandom_range(0, 4000), $urandom_range(0, 7), 1'($urandom_range(0, 1)));
			// The second chunk runs with no idling on either side.
			idling_on = (chunk != 1);
			for (int i = 0; i < 450; i++) begin
				// Mostly narrow bands so that row ranges land near the threshold.
				if (i % 90 == 0) begin
					base_r = 8'($urandom_range(248));
					base_g = 8'($urandom_range(248));
					base_b = 8'($urandom_range(248));
				end
				if (chunk == 0 && $urandom_range(9) == 0) begin
					send_random_pixel();
				end else begin
					send_pixel(8'(base_r + $urandom_range(7)), 8'(base_g + $urandom_range(7)),
						8'(base_b + $urandom_range(7)));
				end
			end
			wait_drained();
		end
		idling_on = 1'b1;
	endtask

	task automatic test_backpressure();
		@(negedge clk) hold_left = 400;
		@(posedge clk);
		repeat (300) send_random_pixel();
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idling_on = 1'b1;
		test_directed_pixels();
		test_backpressure();
		test_row_end(1'b0);
		test_random_rows();
		test_row_end(1'b1);
		repeat (16) @(posedge clk);
		$display("Sent %0d pixels and checked %0d words; %0d row ends, %0d kept, %0d dropped.",
			pixels_sent, words_seen, rows_seen, rows_kept, drop_total);
		$display("Channel counts 0 to 7, both polarities, a threshold on each side of a row range, a long stall.");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/p2w_pkg.sv
rtl/core/p2w_sample_path.sv
rtl/core/pixel_to_wavetable_row_trim.sv
tb/tb_pixel_to_wavetable_row_trim.sv
